FILE: src/crow_pkg.sv
// ----------------------------------------------------------------------------
// crow_pkg: shared types and constants of the rectangle outline writer
// Command word passed from the front end to the back end, phase codes,
// register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package crow_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_FRAME_BASE      = 2'd0;
    localparam logic [1:0] REG_SURFACE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_SURFACE_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_HALFWORD_PIXELS = 2'd3;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam int DIM_BITS   = 13;     // surface size registers, row pitch
    localparam int ADDR_BITS  = 32;
    localparam int COLOR_BITS = 16;
    localparam int IN_COORD_BITS = 14;  // signed rectangle fields
    localparam int CLIP_BITS  = 17;     // signed working width of the clip

    // widest coordinate any COORD_BITS setting produces
    localparam int COORD_BITS_MAX = 16;
    localparam int COORD_BITS_DEF = 13;
    localparam int PROD_BITS      = COORD_BITS_MAX + DIM_BITS;

    localparam logic [ADDR_BITS-1:0] RST_FRAME_BASE     = '0;
    localparam logic [DIM_BITS-1:0]  RST_SURFACE_WIDTH  = 13'd640;
    localparam logic [DIM_BITS-1:0]  RST_SURFACE_HEIGHT = 13'd480;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;

    localparam int S_TDATA_BITS = 80;
    localparam int M_TDATA_BITS = 48;
    localparam int M_TUSER_BITS = 2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_EDGES = 2'd1,
        PH_SIDES = 2'd2
    } t_phase;

    // start: col/row hold the clipped origin, base the frame base
    // step:  col/row hold the pixel position, base unused
    typedef struct packed {
        logic                       is_start;
        logic [COORD_BITS_MAX-1:0]  col;
        logic [COORD_BITS_MAX-1:0]  row;
        logic [ADDR_BITS-1:0]       base;
        logic [DIM_BITS-1:0]        pitch;
        logic                       halfword;
        logic [COLOR_BITS-1:0]      color;
        logic                       xor_op;
        logic                       last;
    } t_cmd;

endpackage

`default_nettype wire

FILE: src/crow_fifo.sv
// ----------------------------------------------------------------------------
// crow_fifo: command queue between front and back end
// Small register queue; full is taken from the registered fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module crow_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  crow_pkg::t_cmd     i_push_cmd,
    output logic               o_full,
    output logic               o_valid,
    output crow_pkg::t_cmd     o_cmd,
    input  wire logic          i_pop
);

    crow_pkg::t_cmd r_mem [crow_pkg::FIFO_DEPTH];

    logic [crow_pkg::FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [crow_pkg::FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [crow_pkg::FIFO_PTR_BITS:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (crow_pkg::FIFO_PTR_BITS+1)'(crow_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/crow_front.sv
// ----------------------------------------------------------------------------
// crow_front: item intake, clipping and outline sequencing
// Clips start items to the surface and walks the outline on step items,
// pushing one command per start that survives the clip and per pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module crow_front #(
    parameter int COORD_BITS = crow_pkg::COORD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire logic                              i_mode,
    input  wire logic [crow_pkg::IN_COORD_BITS-1:0] i_rect_x,
    input  wire logic [crow_pkg::IN_COORD_BITS-1:0] i_rect_y,
    input  wire logic [crow_pkg::IN_COORD_BITS-1:0] i_rect_width,
    input  wire logic [crow_pkg::IN_COORD_BITS-1:0] i_rect_height,
    input  wire logic [crow_pkg::COLOR_BITS-1:0]    i_border_color,
    input  wire logic                              i_use_xor,
    input  wire logic [crow_pkg::ADDR_BITS-1:0]     i_frame_base,
    input  wire logic [crow_pkg::DIM_BITS-1:0]      i_surface_width,
    input  wire logic [crow_pkg::DIM_BITS-1:0]      i_surface_height,
    input  wire logic                              i_halfword,
    output logic                                   o_push,
    output crow_pkg::t_cmd                         o_cmd
);

    localparam int CW = crow_pkg::CLIP_BITS;
    localparam int EXT = CW - crow_pkg::IN_COORD_BITS;
    localparam logic [CW-1:0] COORD_MAX = CW'((64'd1 << COORD_BITS) - 64'd1);

    crow_pkg::t_phase r_phase, n_phase;
    logic [COORD_BITS-1:0] r_cw, n_cw;
    logic [COORD_BITS-1:0] r_ch, n_ch;
    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic                  r_second, n_second;
    logic [crow_pkg::COLOR_BITS-1:0] r_color, n_color;
    logic                  r_xor, n_xor;

    logic signed [CW-1:0] x, y, w, h;
    logic signed [CW-1:0] sw_e, sh_e;
    logic signed [CW-1:0] xc, yc, wc, hc, wf, hf;
    logic signed [CW-1:0] end_x, end_y;
    logic                 empty;
    logic [COORD_BITS:0]  col_inc;
    logic [COORD_BITS:0]  row_inc;
    logic [COORD_BITS:0]  cw_m1;

    // clip, all terms in parallel: the far edge does not move when the
    // near edge is pulled in to zero
    always_comb begin
        x = {{EXT{i_rect_x[crow_pkg::IN_COORD_BITS-1]}}, i_rect_x};
        y = {{EXT{i_rect_y[crow_pkg::IN_COORD_BITS-1]}}, i_rect_y};
        w = {{EXT{i_rect_width[crow_pkg::IN_COORD_BITS-1]}}, i_rect_width};
        h = {{EXT{i_rect_height[crow_pkg::IN_COORD_BITS-1]}}, i_rect_height};
        sw_e = (CW'(i_surface_width) > COORD_MAX) ? COORD_MAX : CW'(i_surface_width);
        sh_e = (CW'(i_surface_height) > COORD_MAX) ? COORD_MAX : CW'(i_surface_height);
        xc = x[CW-1] ? '0 : x;
        yc = y[CW-1] ? '0 : y;
        wc = x[CW-1] ? w + x : w;
        hc = y[CW-1] ? h + y : h;
        end_x = x + w;
        end_y = y + h;
        wf = (end_x > sw_e) ? sw_e - xc : wc;
        hf = (end_y > sh_e) ? sh_e - yc : hc;
        empty = (wf <= 0) || (hf <= 0);
    end

    assign col_inc = {1'b0, r_col} + 1'b1;
    assign row_inc = {1'b0, r_row} + 1'b1;
    assign cw_m1   = {1'b0, r_cw} - 1'b1;

    always_comb begin
        n_phase  = r_phase;
        n_cw     = r_cw;
        n_ch     = r_ch;
        n_col    = r_col;
        n_row    = r_row;
        n_second = r_second;
        n_color  = r_color;
        n_xor    = r_xor;
        o_push   = 1'b0;
        o_cmd          = '0;
        o_cmd.pitch    = i_surface_width;
        o_cmd.halfword = i_halfword;
        o_cmd.color    = r_color;
        o_cmd.xor_op   = r_xor;

        if (i_accept) begin
            if (!i_mode) begin
                n_phase = crow_pkg::PH_IDLE;
                if (!empty) begin
                    n_cw     = wf[COORD_BITS-1:0];
                    n_ch     = hf[COORD_BITS-1:0];
                    n_color  = i_border_color;
                    n_xor    = i_use_xor;
                    n_col    = COORD_BITS'(1);
                    n_row    = '0;
                    n_second = 1'b0;
                    n_phase  = (wf > 2) ? crow_pkg::PH_EDGES : crow_pkg::PH_SIDES;
                    o_push         = 1'b1;
                    o_cmd.is_start = 1'b1;
                    o_cmd.col      = crow_pkg::COORD_BITS_MAX'(xc[COORD_BITS-1:0]);
                    o_cmd.row      = crow_pkg::COORD_BITS_MAX'(yc[COORD_BITS-1:0]);
                    o_cmd.base     = i_frame_base;
                end
            end else begin
                case (r_phase)
                    crow_pkg::PH_EDGES: begin
                        // top pixel, then bottom pixel of the same column
                        o_push    = 1'b1;
                        o_cmd.col = crow_pkg::COORD_BITS_MAX'(r_col);
                        o_cmd.row = r_second ?
                            crow_pkg::COORD_BITS_MAX'(r_ch - 1'b1) : '0;
                        if (!r_second && (r_ch > COORD_BITS'(1))) begin
                            n_second = 1'b1;
                        end else begin
                            n_second = 1'b0;
                            n_col    = col_inc[COORD_BITS-1:0];
                            if (col_inc >= cw_m1) begin
                                n_phase = crow_pkg::PH_SIDES;
                                n_row   = '0;
                            end
                        end
                    end
                    crow_pkg::PH_SIDES: begin
                        o_push    = 1'b1;
                        o_cmd.row = crow_pkg::COORD_BITS_MAX'(r_row);
                        o_cmd.col = r_second ?
                            crow_pkg::COORD_BITS_MAX'(r_cw - 1'b1) : '0;
                        if (!r_second && (r_cw > COORD_BITS'(1))) begin
                            n_second = 1'b1;
                        end else begin
                            n_second = 1'b0;
                            n_row    = row_inc[COORD_BITS-1:0];
                            if (row_inc >= {1'b0, r_ch}) begin
                                n_phase    = crow_pkg::PH_IDLE;
                                o_cmd.last = 1'b1;
                            end
                        end
                    end
                    default: begin
                        o_push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= crow_pkg::PH_IDLE;
            r_cw     <= '0;
            r_ch     <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_second <= 1'b0;
            r_color  <= '0;
            r_xor    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cw     <= n_cw;
            r_ch     <= n_ch;
            r_col    <= n_col;
            r_row    <= n_row;
            r_second <= n_second;
            r_color  <= n_color;
            r_xor    <= n_xor;
        end
    end

endmodule

`default_nettype wire

FILE: src/crow_back.sv
// ----------------------------------------------------------------------------
// crow_back: address pipeline and output register
// Stage A multiplies row by pitch; the output stage adds the column,
// scales by pixel size and adds the origin. Start commands end in the
// origin register and produce no transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module crow_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cmd_valid,
    input  crow_pkg::t_cmd                         i_cmd,
    output logic                                   o_cmd_pop,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [crow_pkg::ADDR_BITS-1:0]          o_write_address,
    output logic [crow_pkg::COLOR_BITS-1:0]         o_pixel_value,
    output logic                                   o_xor_write,
    output logic                                   o_halfword_write,
    output logic                                   o_last_pixel
);

    localparam int OFF_BITS = crow_pkg::PROD_BITS + 1;

    // stage A
    logic                                 r_a_vld;
    logic                                 r_a_start;
    logic [crow_pkg::COORD_BITS_MAX-1:0]  r_a_col;
    logic [crow_pkg::PROD_BITS-1:0]       r_a_prod;
    logic [crow_pkg::ADDR_BITS-1:0]       r_a_base;
    logic                                 r_a_hw;
    logic [crow_pkg::COLOR_BITS-1:0]      r_a_color;
    logic                                 r_a_xor;
    logic                                 r_a_last;

    logic [crow_pkg::ADDR_BITS-1:0]       r_origin;

    logic                                 r_o_vld;

    logic                                 out_free;
    logic                                 a_adv;
    logic                                 a_free;
    logic [OFF_BITS-1:0]                  offset;
    logic [OFF_BITS:0]                    scaled;
    logic [crow_pkg::ADDR_BITS-1:0]       addr;

    assign out_free  = !r_o_vld || i_ready;
    assign a_adv     = r_a_vld && (r_a_start || out_free);
    assign a_free    = !r_a_vld || a_adv;
    assign o_cmd_pop = i_cmd_valid && a_free;
    assign o_valid   = r_o_vld;

    always_comb begin
        offset = OFF_BITS'(r_a_col) + OFF_BITS'(r_a_prod);
        scaled = r_a_hw ? {offset, 1'b0} : {1'b0, offset};
        addr   = (r_a_start ? r_a_base : r_origin) + crow_pkg::ADDR_BITS'(scaled);
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_a_start <= i_cmd.is_start;
            r_a_col   <= i_cmd.col;
            r_a_prod  <= crow_pkg::PROD_BITS'(i_cmd.row) *
                         crow_pkg::PROD_BITS'(i_cmd.pitch);
            r_a_base  <= i_cmd.base;
            r_a_hw    <= i_cmd.halfword;
            r_a_color <= i_cmd.color;
            r_a_xor   <= i_cmd.xor_op;
            r_a_last  <= i_cmd.last;
        end
        if (a_adv && !r_a_start) begin
            o_write_address  <= addr;
            o_pixel_value    <= r_a_hw ? r_a_color :
                                {{(crow_pkg::COLOR_BITS-8){1'b0}}, r_a_color[7:0]};
            o_xor_write      <= r_a_xor;
            o_halfword_write <= r_a_hw;
            o_last_pixel     <= r_a_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_o_vld  <= 1'b0;
            r_origin <= '0;
        end else begin
            if (a_free) begin
                r_a_vld <= i_cmd_valid;
            end
            if (a_adv && r_a_start) begin
                r_origin <= addr;
            end
            if (a_adv && !r_a_start) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/clipped_rectangle_outline_writer_top.sv
// ----------------------------------------------------------------------------
// clipped_rectangle_outline_writer_top: clipped rectangle outline writer
// Clips a rectangle to the surface and issues one pixel write per step.
//
//   channel   dir  handshake               payload
//   s         in   i_s_tvalid/o_s_tready   tdata rect fields, tuser mode
//   m         out  o_m_tvalid/i_m_tready   tdata addr/pixel, tuser flags, tlast
//   cfg       in   i_cfg_valid/o_cfg_ready index + 32-bit data
//
// One item per cycle sustained while the queue has room; a step transfer
// passes the queue, stage A and output register. Limits are the front-end
// sequencer (one outline step per cycle) and row-times-pitch multiplier.
// Start items produce no output; the origin is computed in the back end.
// A four-entry command queue absorbs output stalls; s stalls only when full.
// Synchronous reset clears control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_rectangle_outline_writer_top #(
    parameter int COORD_BITS = crow_pkg::COORD_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // rect_x[13:0] rect_y[27:14] rect_width[41:28] rect_height[55:42]
    // border_color[71:56] use_xor[72], zero above
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [crow_pkg::S_TDATA_BITS-1:0]    i_s_tdata,
    input  wire logic                                i_s_tuser,   // mode
    // write_address[31:0] pixel_value[47:32]
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [crow_pkg::M_TDATA_BITS-1:0]         o_m_tdata,
    output logic [crow_pkg::M_TUSER_BITS-1:0]         o_m_tuser,  // xor_write[0] halfword_write[1]
    output logic                                     o_m_tlast,  // last_pixel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [crow_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [crow_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    logic [crow_pkg::ADDR_BITS-1:0] r_frame_base;
    logic [crow_pkg::DIM_BITS-1:0]  r_surface_width;
    logic [crow_pkg::DIM_BITS-1:0]  r_surface_height;
    logic                           r_halfword;

    logic           in_accept;
    logic           push;
    crow_pkg::t_cmd push_cmd;
    logic           fifo_full;
    logic           fifo_valid;
    crow_pkg::t_cmd fifo_cmd;
    logic           pop;

    logic [crow_pkg::ADDR_BITS-1:0]  write_address;
    logic [crow_pkg::COLOR_BITS-1:0] pixel_value;
    logic                            xor_write;
    logic                            halfword_write;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !fifo_full;
    assign in_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base     <= crow_pkg::RST_FRAME_BASE;
            r_surface_width  <= crow_pkg::RST_SURFACE_WIDTH;
            r_surface_height <= crow_pkg::RST_SURFACE_HEIGHT;
            r_halfword       <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                crow_pkg::REG_FRAME_BASE:
                    r_frame_base <= i_cfg_data[crow_pkg::ADDR_BITS-1:0];
                crow_pkg::REG_SURFACE_WIDTH:
                    r_surface_width <= i_cfg_data[crow_pkg::DIM_BITS-1:0];
                crow_pkg::REG_SURFACE_HEIGHT:
                    r_surface_height <= i_cfg_data[crow_pkg::DIM_BITS-1:0];
                crow_pkg::REG_HALFWORD_PIXELS:
                    r_halfword <= i_cfg_data[0];
                default: begin
                    r_halfword <= r_halfword;
                end
            endcase
        end
    end

    crow_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_mode           (i_s_tuser),
        .i_rect_x         (i_s_tdata[13:0]),
        .i_rect_y         (i_s_tdata[27:14]),
        .i_rect_width     (i_s_tdata[41:28]),
        .i_rect_height    (i_s_tdata[55:42]),
        .i_border_color   (i_s_tdata[71:56]),
        .i_use_xor        (i_s_tdata[72]),
        .i_frame_base     (r_frame_base),
        .i_surface_width  (r_surface_width),
        .i_surface_height (r_surface_height),
        .i_halfword       (r_halfword),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    crow_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (fifo_full),
        .o_valid    (fifo_valid),
        .o_cmd      (fifo_cmd),
        .i_pop      (pop)
    );

    crow_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (fifo_valid),
        .i_cmd            (fifo_cmd),
        .o_cmd_pop        (pop),
        .o_valid          (o_m_tvalid),
        .i_ready          (i_m_tready),
        .o_write_address  (write_address),
        .o_pixel_value    (pixel_value),
        .o_xor_write      (xor_write),
        .o_halfword_write (halfword_write),
        .o_last_pixel     (o_m_tlast)
    );

    assign o_m_tdata = {pixel_value, write_address};
    assign o_m_tuser = {halfword_write, xor_write};

endmodule

`default_nettype wire
